>>> sv/descending_sort_with_tags_top_assert.svh
// Assertion macros shared by the descending sort checker
`ifndef DESCENDING_SORT_WITH_TAGS_TOP_ASSERT_SVH
`define DESCENDING_SORT_WITH_TAGS_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset
`define DSORT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("descending sort check failed");

// Check a property on every clock edge, reset included
`define DSORT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("descending sort reset check failed");

`endif

>>> sv/dsort_pkg.sv
// Shared constants and types for the descending key sort with tags
`timescale 1ns / 1ps
`default_nettype none
package dsort_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int KEY_W     = 32;
  localparam int TAG_W     = 16;

  // One input beat
  typedef struct packed {
    logic signed [KEY_W-1:0] key_in;
    logic        [TAG_W-1:0] tag_in;
    logic                    last_in;
  } in_t;

  // One result beat
  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic        [TAG_W-1:0] tag_out;
    logic                    last_out;
  } out_t;

  // Contents of one cell of the chain
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
  } cell_t;

  // Chain-wide commands, at most one active per cycle
  typedef struct packed {
    logic load;
    logic drain;
  } ctl_t;

endpackage
`default_nettype wire

>>> sv/dsort_cell.sv
// One insertion cell of the sorting chain
`timescale 1ns / 1ps
`default_nettype none
module dsort_cell (
  input  logic             clk,
  input  logic             rst,
  input  dsort_pkg::ctl_t  ctl,
  input  dsort_pkg::cell_t new_cell,
  input  dsort_pkg::cell_t prev,
  input  logic             prev_ins,
  input  dsort_pkg::cell_t next,
  output dsort_pkg::cell_t cur,
  output logic             ins
);
  import dsort_pkg::*;

  // New key lands here or above: cell empty or new key strictly larger
  assign ins = !cur.valid || ($signed(new_cell.key) > $signed(cur.key));

  // Drain: take the neighbour below; load: shift down or take the new key
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (ctl.drain) begin
      cur <= next;
    end else if (ctl.load && ins) begin
      cur <= prev_ins ? prev : new_cell;
    end
  end

endmodule
`default_nettype wire

>>> sv/descending_sort_with_tags_top.sv
// An item is inserted into the chain as it is taken. The first result of a batch
// passes the drain flag and then the output register after its closing item, then
// one result per cycle follows while not stalled. The cell chain either inserts
// or shifts out in a given cycle, so items are inserted and drained in turn.
// The input is stalled while a batch drains. Reset empties the chain and the
// output register.
`timescale 1ns / 1ps
`default_nettype none
module descending_sort_with_tags_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  dsort_pkg::in_t  item,
  output logic            result_valid,
  input  logic            result_stall,
  output dsort_pkg::out_t result
);
  import dsort_pkg::*;

  cell_t                cell_q [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] ins_v;
  cell_t                new_cell;
  ctl_t                 ctl;
  logic                 draining;
  logic                 accept;
  logic                 pop;

  // Handshake and chain commands
  assign item_stall = draining;
  assign accept     = item_valid && !item_stall;
  assign pop        = draining && cell_q[0].valid && (!result_valid || !result_stall);
  assign ctl.load   = accept;
  assign ctl.drain  = pop;
  assign new_cell   = '{valid: 1'b1, key: item.key_in, tag: item.tag_in};

  // Build the chain
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    cell_t prev_c;
    cell_t next_c;
    logic  prev_i;
    if (i == 0) begin : g_head
      assign prev_c = '0;
      assign prev_i = 1'b0;
    end else begin : g_body
      assign prev_c = cell_q[i-1];
      assign prev_i = ins_v[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_c = '0;
    end else begin : g_mid
      assign next_c = cell_q[i+1];
    end
    dsort_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .new_cell (new_cell),
      .prev     (prev_c),
      .prev_ins (prev_i),
      .next     (next_c),
      .cur      (cell_q[i]),
      .ins      (ins_v[i])
    );
  end

  // Enter drain on the closing beat or when the chain fills, leave when the last cell is popped
  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
    end else if (accept && (item.last_in || cell_q[MAX_ITEMS-2].valid)) begin
      draining <= 1'b1;
    end else if (pop && !cell_q[1].valid) begin
      draining <= 1'b0;
    end
  end

  // Output register: hold while stalled, advance on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.key_out  <= cell_q[0].key;
      result.tag_out  <= cell_q[0].tag;
      result.last_out <= !cell_q[1].valid;
    end
  end

endmodule
`default_nettype wire

>>> sv/dsort_checker.sv
// Port-level checks for the descending sort, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "descending_sort_with_tags_top_assert.svh"
module dsort_checker (
  input logic            clk,
  input logic            rst,
  input logic            item_valid,
  input logic            item_stall,
  input dsort_pkg::in_t  item,
  input logic            result_valid,
  input logic            result_stall,
  input dsort_pkg::out_t result
);
  import dsort_pkg::*;

  logic item_beat;
  logic result_held;
  assign item_beat   = item_valid && !item_stall;
  assign result_held = result_valid && result_stall;

  // A stalled result beat holds
  `DSORT_ASSERT(a_result_hold, clk, rst, result_held |=> result_valid && $stable(result))
  // A closing beat blocks further input while the batch drains
  `DSORT_ASSERT(a_last_blocks, clk, rst, item_beat && item.last_in |=> item_stall)
  // Reset leaves no result pending and the input open
  `DSORT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid && !item_stall)

endmodule

bind descending_sort_with_tags_top dsort_checker u_dsort_checker (.*);
`default_nettype wire

>>> verif/descending_sort_with_tags_top_tb.sv
// Self-checking testbench for the descending key sort with tags
`timescale 1ns / 1ps
module descending_sort_with_tags_top_tb;
  import dsort_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 24;
  localparam int RANDOM_ITEMS = 160;

  // Keeps the batch in sorted order and the result beats still owed
  class sort_board;
    int         held_keys[$];
    bit [15:0]  held_tags[$];
    out_t       sorted_due[$];
    int         errors;

    // Place an accepted item into the held list; emit the batch when it closes
    function void note_item(in_t beat);
      int   pos;
      int   key;
      out_t res;
      key = $signed(beat.key_in);
      pos = 0;
      // equal keys go after those already held
      while (pos < held_keys.size() && held_keys[pos] >= key) pos++;
      held_keys.insert(pos, key);
      held_tags.insert(pos, beat.tag_in);
      if (beat.last_in || held_keys.size() == MAX_ITEMS) begin
        foreach (held_keys[k]) begin
          res.key_out  = held_keys[k];
          res.tag_out  = held_tags[k];
          res.last_out = (k == held_keys.size() - 1);
          sorted_due.push_back(res);
        end
        held_keys.delete();
        held_tags.delete();
      end
    endfunction

    // Compare a result beat with the oldest one owed
    function void check_result(out_t got);
      out_t want;
      if (sorted_due.size() == 0) begin
        $error("unexpected result beat: key_out %0d tag_out %0d last_out %0b",
               $signed(got.key_out), got.tag_out, got.last_out);
        errors++;
        return;
      end
      want = sorted_due.pop_front();
      if (got.key_out !== want.key_out) begin
        $error("key_out mismatch: expected %0d, got %0d",
               $signed(want.key_out), $signed(got.key_out));
        errors++;
      end
      if (got.tag_out !== want.tag_out) begin
        $error("tag_out mismatch: expected %0d, got %0d", want.tag_out, got.tag_out);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out mismatch: expected %0b, got %0b", want.last_out, got.last_out);
        errors++;
      end
    endfunction

    function int pending();
      return sorted_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  in_t  item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_t result;

  sort_board   board = new();
  int unsigned cycle_count = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;

  descending_sort_with_tags_top u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result side on a pattern chosen by bits 7:6 of the cycle count
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case (cycle_count[7:6])
      2'd0: result_stall <= 1'b0;
      2'd1: result_stall <= ($urandom_range(0, 3) == 0);
      2'd2: result_stall <= ($urandom_range(0, 9) < 6);
      default: result_stall <= (cycle_count[1:0] == 2'd3);
    endcase
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) board.check_result(result);
  end

  // Drive one beat in bursts with random gaps, hold until accepted
  task automatic send_item(input in_t beat);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    item       <= beat;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    board.note_item(beat);
  endtask

  task automatic send_directed(input int key, input int tag, input bit last);
    in_t beat;
    beat.key_in  = key;
    beat.tag_in  = tag[15:0];
    beat.last_in = last;
    send_item(beat);
  endtask

  // Drop valid and wait until every owed result has arrived
  task automatic hold_until_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic int pick_key();
    case ($urandom_range(0, 5))
      0: return int'($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Send a batch of random content; a full batch closes on its own
  task automatic send_batch(input int len, input bit fill_last);
    in_t beat;
    for (int i = 0; i < len; i++) begin
      beat.key_in  = pick_key();
      beat.tag_in  = $urandom_range(0, 1) ? 16'(i) : 16'($urandom());
      beat.last_in = (i == len - 1) ? ((len == MAX_ITEMS) ? fill_last : 1'b1) : 1'b0;
      send_item(beat);
    end
  endtask

  initial begin
    int sent;
    int batch_no;
    int len;
    int roll;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Batches of one at the extremes
    send_directed(0, 0, 1'b1);
    send_directed(32'h7fff_ffff, 16'hffff, 1'b1);
    // Extreme keys with repeats
    send_directed(32'h8000_0000, 0, 1'b0);
    send_directed(32'h7fff_ffff, 1, 1'b0);
    send_directed(-1, 2, 1'b0);
    send_directed(0, 3, 1'b0);
    send_directed(1, 4, 1'b0);
    send_directed(32'h8000_0000, 5, 1'b0);
    send_directed(32'h7fff_ffff, 16'hffff, 1'b1);
    // Equal keys must keep arrival order
    send_directed(5, 10, 1'b0);
    send_directed(-5, 20, 1'b0);
    send_directed(5, 11, 1'b0);
    send_directed(5, 12, 1'b0);
    send_directed(-5, 21, 1'b0);
    send_directed(5, 13, 1'b1);
    // Ascending arrival, fully reversed on output
    send_directed(1, 16'h5555, 1'b0);
    send_directed(2, 16'haaaa, 1'b0);
    send_directed(3, 16'h00ff, 1'b0);
    send_directed(4, 16'hff00, 1'b1);
    hold_until_drained();

    // Random batches, mostly short, with full batches now and then
    sent = 0;
    batch_no = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 99);
      if (batch_no == 2 || batch_no == 6 || roll < 4) len = MAX_ITEMS;
      else if (roll < 14) len = $urandom_range(13, 40);
      else len = $urandom_range(1, 12);
      send_batch(len, (batch_no == 2) ? 1'b0 : 1'($urandom_range(0, 1)));
      sent += len;
      batch_no++;
      if ($urandom_range(0, 5) == 0) hold_until_drained();
    end

    // Let the last batch drain, then wait out the tail
    item_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/dsort_pkg.sv
sv/dsort_cell.sv
sv/descending_sort_with_tags_top.sv
sv/dsort_checker.sv
verif/descending_sort_with_tags_top_tb.sv
